/* rtl/maze_carver_defines.svh */
// ----------------------------------------------------------------------------
// maze_carver_defines
// assertion macros used by the maze carver checker
// ----------------------------------------------------------------------------
`ifndef MAZE_CARVER_DEFINES_SVH
`define MAZE_CARVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MZC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MZC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mzc_pkg.sv */
// ----------------------------------------------------------------------------
// mzc_pkg
// types and constants of the maze carver
// ----------------------------------------------------------------------------
package mzc_pkg;

  localparam int OP_W     = 2;
  localparam int RAND_W   = 16;
  localparam int CELL_W   = 12;
  localparam int DIR_W    = 2;
  localparam int WALL_W   = 4;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;
  // holds any grid dimension up to the largest supported size
  localparam int DIM_W    = 9;
  localparam int MIN_DIM  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_CARVE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } mzc_op_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } mzc_dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'd0,
    CFG_GRID_HEIGHT = 1'd1
  } mzc_cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DIV,
    S_CHECK,
    S_SCAN,
    S_CARVE_FROM,
    S_CARVE_TO
  } mzc_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [RAND_W-1:0] random_value;
    logic [CELL_W-1:0] read_index;
  } mzc_cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [DIR_W-1:0]  carved_direction;
    logic              carved;
    logic [WALL_W-1:0] walls_open;
    logic              done_res;
  } mzc_result_t;

endpackage

/* rtl/mzc_cell_mem.sv */
// ----------------------------------------------------------------------------
// mzc_cell_mem
// passage store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module mzc_cell_mem
  import mzc_pkg::*;
#(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WALL_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WALL_W-1:0] rdata
);

  logic [WALL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mzc_mod_unit.sv */
// ----------------------------------------------------------------------------
// mzc_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module mzc_mod_unit
  import mzc_pkg::*;
#(
  parameter int DVD_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             valid,
  output logic [DIM_W-1:0] rem
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             run;
  logic [CW-1:0]    cnt;
  logic [DVD_W-1:0] dvd;
  logic [DIM_W-1:0] dsr;
  logic [DIM_W:0]   shifted;
  logic [DIM_W:0]   rem_next;

  assign shifted  = {rem, dvd[DVD_W-1]};
  assign rem_next = (shifted >= {1'b0, dsr}) ? shifted - {1'b0, dsr} : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else begin
      valid <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DVD_W);
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
      end else if (run) begin
        rem <= rem_next[DIM_W-1:0];
        dvd <= dvd << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run   <= 1'b0;
          valid <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/maze_carver.sv */
// ----------------------------------------------------------------------------
// maze_carver
// hunt-and-kill maze generator over a passage store of 4-bit cells
// ----------------------------------------------------------------------------
// one word in flight; a new word is accepted only while the block is idle
// carve: a check reads the cursor and its neighbors (5 reads), then the from and
//   to cells are written (2 writes); each hunt lap scans cells before a new check;
//   a geometry write first recomputes the column; start runs a clearing sweep
// reset: synchronous; busy while the store is swept to zero; results are never
//   stalled by the receiver
module maze_carver
  import mzc_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  mzc_cmd_t             cmd,
  output logic                 strobe,
  output mzc_result_t          result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W = $clog2(STORE);
  localparam int CNT_W = $clog2(STORE + 1);
  // room for cursor plus width without overflow
  localparam int AW    = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(STORE - 1);
  localparam logic [2:0] CHK_LAST = 3'd5;

  // ---------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] ve;
    ve = DIM_W'(v);
    if (ve < DIM_W'(MIN_DIM)) return DIM_W'(MIN_DIM);
    if (ve > hi) return hi;
    return ve;
  endfunction

  // 4 is 1 mod 3, so the base-4 digit sum keeps the residue
  function automatic logic [1:0] mod3_16(input logic [RAND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < RAND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) t = t - 3'd6;
    else if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // k-th set bit of the free-neighbor mask, in up, right, down, left order
  function automatic logic [DIR_W-1:0] pick_dir(input logic [3:0] mask,
                                                input logic [1:0] k);
    logic [2:0]       seen;
    logic [DIR_W-1:0] d;
    seen = '0;
    d    = '0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == 3'(k)) d = DIR_W'(i);
        seen = seen + 3'd1;
      end
    end
    return d;
  endfunction

  // next cell with wrap, carrying its column
  function automatic logic [IDX_W+DIM_W-1:0] step_fwd(input logic [IDX_W-1:0] a,
                                                      input logic [DIM_W-1:0] c,
                                                      input logic [CNT_W-1:0] n,
                                                      input logic [DIM_W-1:0] w);
    logic [AW-1:0]    a1;
    logic [DIM_W-1:0] c1;
    a1 = AW'(a) + AW'(1);
    c1 = c + DIM_W'(1);
    if (a1 >= AW'(n)) return '0;
    if (c1 == w) c1 = '0;
    return {a1[IDX_W-1:0], c1};
  endfunction

  // ---------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------
  mzc_state_t state, state_next;

  logic [CFG_W-1:0]  grid_width;
  logic [CFG_W-1:0]  grid_height;

  logic [IDX_W-1:0]  cursor;
  logic [DIM_W-1:0]  col;        // cursor column, kept beside the cursor
  logic              dirty;      // column stale after a geometry write
  logic [CNT_W-1:0]  visits;

  logic [IDX_W-1:0]  clr_ptr;
  logic              clr_reply;  // sweep came from a start word

  // per-word copies
  logic [DIM_W-1:0]  w_q;
  logic [CNT_W-1:0]  n_q;
  logic [1:0]        rnd_lo;
  logic [1:0]        rnd_m3;
  logic [CELL_W-1:0] ridx_q;
  logic              rd_ok;

  // neighbor check
  logic [2:0]        chk_k;
  logic [WALL_W-1:0] from_data;
  logic [2:0]        empty_mask;
  logic [DIR_W-1:0]  dir_q;
  logic [IDX_W-1:0]  to_addr;
  logic [DIM_W-1:0]  to_col;

  // hunt scan
  logic [CNT_W-1:0]  lap;
  logic [IDX_W-1:0]  scan_addr;
  logic [DIM_W-1:0]  scan_col;
  logic              pend;
  logic [IDX_W-1:0]  pend_addr;
  logic [DIM_W-1:0]  pend_col;
  logic [CNT_W-1:0]  resp;

  // memory and remainder unit
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WALL_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WALL_W-1:0] mem_rdata;
  logic              div_start;
  logic              div_valid;
  logic [DIM_W-1:0]  div_rem;

  logic              emit;
  mzc_result_t       res_d;

  // ---------------------------------------------------------------------
  // geometry and accept-time values
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0]   w_cfg, h_cfg;
  logic [2*DIM_W-1:0] area;
  logic [CNT_W-1:0]   n_cfg;
  logic               accept;
  logic               wrap;
  logic [IDX_W-1:0]   cur_eff;
  logic [DIM_W-1:0]   col_eff;
  logic               dirty_eff;
  logic               rd_ok_now;

  assign w_cfg = clamp_dim(grid_width, DIM_W'(MAX_WIDTH));
  assign h_cfg = clamp_dim(grid_height, DIM_W'(MAX_HEIGHT));
  assign area  = (2*DIM_W)'(w_cfg) * (2*DIM_W)'(h_cfg);
  assign n_cfg = CNT_W'(area);

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  // cursor left outside a shrunken grid restarts at cell 0
  assign wrap      = (CNT_W'(cursor) >= n_cfg);
  assign cur_eff   = wrap ? '0 : cursor;
  assign col_eff   = wrap ? '0 : col;
  assign dirty_eff = wrap ? 1'b0 : dirty;
  assign rd_ok_now = (32'(cmd.read_index) < 32'(n_cfg));

  // ---------------------------------------------------------------------
  // neighbors of the cursor
  // ---------------------------------------------------------------------
  logic [AW-1:0]    cur_a, w_a, n_a;
  logic [3:0]       nb_ok;
  logic [IDX_W-1:0] up_addr, rt_addr, dn_addr, lf_addr;
  logic [3:0]       mask_full;
  logic [2:0]       free_cnt;
  logic [1:0]       k_sel;
  logic [DIR_W-1:0] dir_pick;
  logic             scan_hit, scan_miss;

  assign cur_a = AW'(cursor);
  assign w_a   = AW'(w_q);
  assign n_a   = AW'(n_q);

  assign nb_ok[DIR_UP]    = (cur_a >= w_a);
  assign nb_ok[DIR_RIGHT] = (cur_a + AW'(1) < n_a) && (AW'(col) + AW'(1) != w_a);
  assign nb_ok[DIR_DOWN]  = (cur_a + w_a < n_a);
  assign nb_ok[DIR_LEFT]  = (col != '0);

  assign up_addr = IDX_W'(cur_a - w_a);
  assign rt_addr = IDX_W'(cur_a + AW'(1));
  assign dn_addr = IDX_W'(cur_a + w_a);
  assign lf_addr = IDX_W'(cur_a - AW'(1));

  // left answer arrives in the last check cycle
  assign mask_full = {nb_ok[DIR_LEFT] && (mem_rdata == '0), empty_mask};
  assign free_cnt  = 3'($countones(mask_full));

  always_comb begin
    unique case (free_cnt)
      3'd2:    k_sel = {1'b0, rnd_lo[0]};
      3'd3:    k_sel = rnd_m3;
      3'd4:    k_sel = rnd_lo;
      default: k_sel = 2'd0;
    endcase
  end

  assign dir_pick  = pick_dir(mask_full, k_sel);

  assign scan_hit  = pend && (mem_rdata != '0);
  assign scan_miss = pend && !scan_hit && (resp + CNT_W'(1) == n_q);

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_ptr == LAST_CELL) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode)
            OP_START: state_next = S_CLEAR;
            OP_CARVE: begin
              if (visits == '0) state_next = S_IDLE;
              else if (dirty_eff) state_next = S_DIV;
              else state_next = S_CHECK;
            end
            OP_READ:  state_next = S_READ;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_IDLE;
      S_DIV: begin
        if (div_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (chk_k == CHK_LAST) begin
          state_next = (free_cnt != '0) ? S_CARVE_FROM : S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (scan_hit) state_next = (lap == n_q) ? S_IDLE : S_CHECK;
        else if (scan_miss) state_next = S_IDLE;
      end
      S_CARVE_FROM: state_next = S_CARVE_TO;
      S_CARVE_TO:   state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // memory controls and result word
  // ---------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor;
    mem_wdata = '0;
    mem_raddr = '0;
    emit      = 1'b0;
    res_d     = '0;
    div_start = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr;
        if (clr_ptr == LAST_CELL && clr_reply) begin
          emit           = 1'b1;
          res_d.done_res = (n_q == CNT_W'(1));
        end
      end
      S_IDLE: begin
        mem_raddr = rd_ok_now ? IDX_W'(cmd.read_index) : '0;
        res_d.cell_index = CELL_W'(cur_eff);
        res_d.done_res   = (visits == '0);
        if (accept) begin
          if (cmd.opcode == OP_CARVE) begin
            emit      = (visits == '0);
            div_start = (visits != '0) && dirty_eff;
          end else if (cmd.opcode == OP_NONE) begin
            emit = 1'b1;
          end
        end
      end
      S_READ: begin
        emit             = 1'b1;
        res_d.cell_index = ridx_q;
        res_d.walls_open = rd_ok ? mem_rdata : '0;
        res_d.done_res   = (visits == '0);
      end
      S_DIV: ;
      S_CHECK: begin
        unique case (chk_k)
          3'd0:    mem_raddr = cursor;
          3'd1:    mem_raddr = nb_ok[DIR_UP]    ? up_addr : '0;
          3'd2:    mem_raddr = nb_ok[DIR_RIGHT] ? rt_addr : '0;
          3'd3:    mem_raddr = nb_ok[DIR_DOWN]  ? dn_addr : '0;
          3'd4:    mem_raddr = nb_ok[DIR_LEFT]  ? lf_addr : '0;
          default: mem_raddr = '0;
        endcase
      end
      S_SCAN: begin
        mem_raddr      = scan_addr;
        res_d.done_res = (visits == '0);
        if (scan_hit && lap == n_q) begin
          emit             = 1'b1;
          res_d.cell_index = CELL_W'(pend_addr);
        end else if (scan_miss) begin
          emit             = 1'b1;
          res_d.cell_index = CELL_W'(cursor);
        end
      end
      S_CARVE_FROM: begin
        // from cell was read during the check; nothing wrote it since
        mem_we    = 1'b1;
        mem_waddr = cursor;
        mem_wdata = from_data | (WALL_W'(1) << dir_q);
      end
      S_CARVE_TO: begin
        // target was empty when checked, so its new word is the one wall
        mem_we                 = 1'b1;
        mem_waddr              = to_addr;
        mem_wdata              = WALL_W'(1) << DIR_W'(dir_q + DIR_W'(2));
        emit                   = 1'b1;
        res_d.cell_index       = CELL_W'(cursor);
        res_d.carved_direction = dir_q;
        res_d.carved           = 1'b1;
        res_d.done_res         = (visits == CNT_W'(1));
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      grid_width  <= CFG_W'(8);
      grid_height <= CFG_W'(8);
      cursor      <= '0;
      col         <= '0;
      dirty       <= 1'b0;
      visits      <= '0;
      clr_ptr     <= '0;
      clr_reply   <= 1'b0;
      chk_k       <= '0;
      lap         <= '0;
      pend        <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (emit) result <= res_d;

      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + IDX_W'(1);
          if (clr_ptr == LAST_CELL) begin
            clr_ptr   <= '0;
            clr_reply <= 1'b0;
            if (clr_reply) begin
              cursor <= '0;
              col    <= '0;
              dirty  <= 1'b0;
              visits <= n_q - CNT_W'(1);
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            w_q    <= w_cfg;
            n_q    <= n_cfg;
            rnd_lo <= cmd.random_value[1:0];
            rnd_m3 <= mod3_16(cmd.random_value);
            ridx_q <= cmd.read_index;
            rd_ok  <= rd_ok_now;
            cursor <= cur_eff;
            col    <= col_eff;
            dirty  <= dirty_eff;
            lap    <= '0;
            chk_k  <= '0;
            if (cmd.opcode == OP_START) clr_reply <= 1'b1;
          end
        end
        S_READ: ;
        S_DIV: begin
          if (div_valid) begin
            col   <= div_rem;
            dirty <= 1'b0;
          end
        end
        S_CHECK: begin
          chk_k <= chk_k + 3'd1;
          unique case (chk_k)
            3'd1: from_data     <= mem_rdata;
            3'd2: empty_mask[0] <= nb_ok[DIR_UP]    && (mem_rdata == '0);
            3'd3: empty_mask[1] <= nb_ok[DIR_RIGHT] && (mem_rdata == '0);
            3'd4: empty_mask[2] <= nb_ok[DIR_DOWN]  && (mem_rdata == '0);
            3'd5: begin
              chk_k <= '0;
              dir_q <= dir_pick;
              unique case (dir_pick)
                DIR_UP:    begin to_addr <= up_addr; to_col <= col;              end
                DIR_RIGHT: begin to_addr <= rt_addr; to_col <= col + DIM_W'(1); end
                DIR_DOWN:  begin to_addr <= dn_addr; to_col <= col;              end
                default:   begin to_addr <= lf_addr; to_col <= col - DIM_W'(1); end
              endcase
              {scan_addr, scan_col} <= step_fwd(cursor, col, n_q, w_q);
              pend <= 1'b0;
              resp <= '0;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (scan_hit) begin
            cursor <= pend_addr;
            col    <= pend_col;
            lap    <= lap + CNT_W'(1);
            pend   <= 1'b0;
          end else if (scan_miss) begin
            pend <= 1'b0;
          end else begin
            // reads issue back to back; each answer comes back in the cycle after its read
            pend      <= 1'b1;
            pend_addr <= scan_addr;
            pend_col  <= scan_col;
            resp      <= resp + CNT_W'(pend);
            {scan_addr, scan_col} <= step_fwd(scan_addr, scan_col, n_q, w_q);
          end
        end
        S_CARVE_FROM: ;
        S_CARVE_TO: begin
          cursor <= to_addr;
          col    <= to_col;
          visits <= visits - CNT_W'(1);
        end
        default: ;
      endcase

      // the user must write geometry only while idle; the block itself does not enforce it
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
        dirty <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // submodules
  // ---------------------------------------------------------------------
  mzc_cell_mem #(
    .DEPTH  (STORE),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mzc_mod_unit #(
    .DVD_W (IDX_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur_eff),
    .divisor  (w_cfg),
    .valid    (div_valid),
    .rem      (div_rem)
  );

endmodule

/* rtl/mzc_checker.sv */
// ----------------------------------------------------------------------------
// mzc_checker
// port-level checks of the maze carver, bound to the top level
// ----------------------------------------------------------------------------
`include "maze_carver_defines.svh"

module mzc_checker
  import mzc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input mzc_result_t result
);

  // an accepted word either answers at once or keeps the block busy
  `MZC_ASSERT_NEXT(a_accept_moves, clk, rst, start && !busy, busy || strobe, "accepted word lost")

  // every answer leaves the block free for the next word
  `MZC_ASSERT_SAME(a_strobe_idle, clk, rst, strobe, !busy, "strobe while busy")

  // no answer without a word in flight
  `MZC_ASSERT_SAME(a_strobe_cause, clk, rst, strobe, $past(start && !busy) || $past(busy), "spurious strobe")

  // direction is only reported for an opened passage
  `MZC_ASSERT_SAME(a_dir_carved, clk, rst, strobe && !result.carved, result.carved_direction == '0, "direction without carve")

endmodule

bind maze_carver mzc_checker u_checker (.*);
